// ----- rtl/nfa_pkg.sv -----
// ----------------------------------------------------------------------------
// nfa_pkg: shared types and constants of the NAND flash array model
// Request and response words, queue entries, status and request codes.
// ----------------------------------------------------------------------------
package nfa_pkg;

	// default geometry limits
	localparam int MAX_BANKS_DEF   = 4;
	localparam int MAX_BLOCKS_DEF  = 64;
	localparam int MAX_PAGES_DEF   = 64;
	localparam int QUEUE_DEPTH_DEF = 2;

	// page layout
	localparam int PAGE_BYTES  = 32;
	localparam int SPARE_BYTES = 4;
	localparam int LANE_W      = 64;
	localparam int SPARE_W     = SPARE_BYTES * 8;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_BANKS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAGES  = 2'd2;

	localparam logic [2:0] BANKS_RST  = 3'd4;
	localparam logic [6:0] BLOCKS_RST = 7'd64;
	localparam logic [6:0] PAGES_RST  = 7'd64;

	// request type codes
	localparam logic [1:0] REQ_PROGRAM = 2'd0;
	localparam logic [1:0] REQ_READ    = 2'd1;
	localparam logic [1:0] REQ_ERASE   = 2'd2;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_INVALID   = 3'd1,
		ST_OVERWRITE = 3'd2,
		ST_POSITION  = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	// operation as classified by the front end
	typedef enum logic [1:0] {
		OP_PROGRAM,
		OP_READ,
		OP_ERASE,
		OP_REJECT
	} op_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [1:0]        bank_addr;
		logic [5:0]        block_addr;
		logic [5:0]        page_addr;
		logic [LANE_W-1:0] wdata0;
		logic [LANE_W-1:0] wdata1;
		logic [LANE_W-1:0] wdata2;
		logic [LANE_W-1:0] wdata3;
		logic [SPARE_W-1:0] wspare;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [LANE_W-1:0] rdata0;
		logic [LANE_W-1:0] rdata1;
		logic [LANE_W-1:0] rdata2;
		logic [LANE_W-1:0] rdata3;
		logic [SPARE_W-1:0] rspare;
	} rsp_t;

	// queue entry between front and back
	typedef struct packed {
		op_t               op;
		logic [1:0]        bank_addr;
		logic [5:0]        block_addr;
		logic [5:0]        page_addr;
		logic [LANE_W-1:0] wdata0;
		logic [LANE_W-1:0] wdata1;
		logic [LANE_W-1:0] wdata2;
		logic [LANE_W-1:0] wdata3;
		logic [SPARE_W-1:0] wspare;
	} cmd_t;

	// one page memory word
	typedef struct packed {
		logic [SPARE_W-1:0] spare;
		logic [LANE_W-1:0]  d3;
		logic [LANE_W-1:0]  d2;
		logic [LANE_W-1:0]  d1;
		logic [LANE_W-1:0]  d0;
	} page_word_t;

	// back end status seen by the front end
	typedef struct packed {
		logic clearing;
	} back_stat_t;

endpackage

// ----- rtl/nfa_if.sv -----
// ----------------------------------------------------------------------------
// nfa_if: request and response channels
// Valid/ready channels carrying one request or response word.
// ----------------------------------------------------------------------------
interface nfa_req_if;
	logic          valid;
	logic          ready;
	nfa_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface nfa_rsp_if;
	logic          valid;
	logic          ready;
	nfa_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/nand_flash_array_model.sv -----
// ----------------------------------------------------------------------------
// nand_flash_array_model: NAND flash array with in-order page programming
// Banks of blocks of pages (32 data + 4 spare bytes per page); program,
// read and erase requests, one status response word per request.
//
// Channel   Dir  Handshake      Payload
// req       in   valid/ready    nfa_pkg::req_t (type, address, page data)
// rsp       out  valid/ready    nfa_pkg::rsp_t (status, read data)
// cfg       in   cfg_we         cfg_idx, cfg_wdata (geometry registers)
//
// In the back end each request is fetched (the block pointer table and the
// page memory are read) and then executed (checked and written back).
// After reset and after any geometry register write, the pointer table is
// swept over all MAX_BANKS * MAX_BLOCKS entries; requests are held off meanwhile.
// A queue of QUEUE_DEPTH words and the response register decouple intake
// from execution, so intake continues while a response waits for ready.
// ----------------------------------------------------------------------------
module nand_flash_array_model #(
	parameter int MAX_BANKS   = nfa_pkg::MAX_BANKS_DEF,
	parameter int MAX_BLOCKS  = nfa_pkg::MAX_BLOCKS_DEF,
	parameter int MAX_PAGES   = nfa_pkg::MAX_PAGES_DEF,
	parameter int QUEUE_DEPTH = nfa_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [nfa_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [nfa_pkg::CFG_DATA_W-1:0] cfg_wdata,
	nfa_req_if.sink                        req,
	nfa_rsp_if.source                      rsp
);

	logic                push;
	nfa_pkg::cmd_t       push_cmd;
	logic                clear_req;
	logic                q_full;
	logic                q_valid;
	logic                q_pop;
	nfa_pkg::cmd_t       q_head;
	nfa_pkg::back_stat_t stat;

	// intake and address check
	nfa_front #(
		.MAX_BANKS  (MAX_BANKS),
		.MAX_BLOCKS (MAX_BLOCKS),
		.MAX_PAGES  (MAX_PAGES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.q_full    (q_full),
		.stat      (stat),
		.push      (push),
		.cmd       (push_cmd),
		.clear_req (clear_req)
	);

	// command queue
	nfa_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.pop       (q_pop),
		.full      (q_full),
		.valid     (q_valid),
		.head      (q_head)
	);

	// execution against pointer table and page memory
	nfa_back #(
		.MAX_BANKS  (MAX_BANKS),
		.MAX_BLOCKS (MAX_BLOCKS),
		.MAX_PAGES  (MAX_PAGES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear_req (clear_req),
		.q_valid   (q_valid),
		.q_cmd     (q_head),
		.q_pop     (q_pop),
		.stat      (stat),
		.rsp       (rsp)
	);

endmodule

// ----- rtl/nfa_front.sv -----
// ----------------------------------------------------------------------------
// nfa_front: request intake and classification
// Holds the geometry registers, checks addresses and pushes commands.
// ----------------------------------------------------------------------------
module nfa_front #(
	parameter int MAX_BANKS  = nfa_pkg::MAX_BANKS_DEF,
	parameter int MAX_BLOCKS = nfa_pkg::MAX_BLOCKS_DEF,
	parameter int MAX_PAGES  = nfa_pkg::MAX_PAGES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [nfa_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [nfa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	nfa_req_if.sink                         req,
	input  logic                            q_full,
	input  nfa_pkg::back_stat_t             stat,
	output logic                            push,
	output nfa_pkg::cmd_t                   cmd,
	output logic                            clear_req
);

	logic [2:0] banks_q;
	logic [6:0] blocks_q;
	logic [6:0] pages_q;
	logic       cfg_known;
	logic       bank_ok;
	logic       blk_ok;
	logic       page_ok;

	// hold the geometry registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			banks_q  <= nfa_pkg::BANKS_RST;
			blocks_q <= nfa_pkg::BLOCKS_RST;
			pages_q  <= nfa_pkg::PAGES_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				nfa_pkg::REG_BANKS:  banks_q  <= cfg_wdata[2:0];
				nfa_pkg::REG_BLOCKS: blocks_q <= cfg_wdata;
				nfa_pkg::REG_PAGES:  pages_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// any known register write erases the whole array
	assign cfg_known = (cfg_idx == nfa_pkg::REG_BANKS) || (cfg_idx == nfa_pkg::REG_BLOCKS)
		|| (cfg_idx == nfa_pkg::REG_PAGES);
	assign clear_req = cfg_we && cfg_known;

	// check against the register and the built-in limit (saturated size)
	assign bank_ok = ({1'b0, req.data.bank_addr} < banks_q)
		&& (32'(req.data.bank_addr) < 32'(MAX_BANKS));
	assign blk_ok  = ({1'b0, req.data.block_addr} < blocks_q)
		&& (32'(req.data.block_addr) < 32'(MAX_BLOCKS));
	assign page_ok = ({1'b0, req.data.page_addr} < pages_q)
		&& (32'(req.data.page_addr) < 32'(MAX_PAGES));

	// classify the request word
	always_comb begin
		cmd.bank_addr  = req.data.bank_addr;
		cmd.block_addr = req.data.block_addr;
		cmd.page_addr  = req.data.page_addr;
		cmd.wdata0     = req.data.wdata0;
		cmd.wdata1     = req.data.wdata1;
		cmd.wdata2     = req.data.wdata2;
		cmd.wdata3     = req.data.wdata3;
		cmd.wspare     = req.data.wspare;
		cmd.op         = nfa_pkg::OP_REJECT;
		case (req.data.req_type)
			nfa_pkg::REQ_PROGRAM: begin
				if (bank_ok && blk_ok && page_ok) cmd.op = nfa_pkg::OP_PROGRAM;
			end
			nfa_pkg::REQ_READ: begin
				if (bank_ok && blk_ok && page_ok) cmd.op = nfa_pkg::OP_READ;
			end
			nfa_pkg::REQ_ERASE: begin
				if (bank_ok && blk_ok) cmd.op = nfa_pkg::OP_ERASE;
			end
			default: cmd.op = nfa_pkg::OP_REJECT;
		endcase
	end

	// stall intake while the queue is full or the pointer table is being cleared
	assign req.ready = !q_full && !stat.clearing && !clear_req;
	assign push      = req.valid && req.ready;

endmodule

// ----- rtl/nfa_queue.sv -----
// ----------------------------------------------------------------------------
// nfa_queue: command queue
// Small FIFO of classified commands between front and back.
// ----------------------------------------------------------------------------
module nfa_queue #(
	parameter int DEPTH = nfa_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  nfa_pkg::cmd_t push_data,
	input  logic          pop,
	output logic          full,
	output logic          valid,
	output nfa_pkg::cmd_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	nfa_pkg::cmd_t    entry_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign valid = (count_q != '0);
	assign head  = entry_q[rd_ptr_q];

	// store the pushed word
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- rtl/nfa_back.sv -----
// ----------------------------------------------------------------------------
// nfa_back: command execution
// Owns the block pointer table and page memory; runs each command through a
// fetch and an execute state and registers the response word.
// ----------------------------------------------------------------------------
module nfa_back #(
	parameter int MAX_BANKS  = nfa_pkg::MAX_BANKS_DEF,
	parameter int MAX_BLOCKS = nfa_pkg::MAX_BLOCKS_DEF,
	parameter int MAX_PAGES  = nfa_pkg::MAX_PAGES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clear_req,
	input  logic                q_valid,
	input  nfa_pkg::cmd_t       q_cmd,
	output logic                q_pop,
	output nfa_pkg::back_stat_t stat,
	nfa_rsp_if.source           rsp
);

	localparam int NumBlocks = MAX_BANKS * MAX_BLOCKS;
	localparam int NumPages  = NumBlocks * MAX_PAGES;
	localparam int BidxW     = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;
	localparam int PidxW     = (NumPages > 1) ? $clog2(NumPages) : 1;
	localparam int PtrW      = $clog2(MAX_PAGES + 1);

	typedef enum logic {S_FETCH, S_EXEC} state_t;

	state_t              state_q;
	logic                clr_q;
	logic [BidxW-1:0]    clr_cnt_q;

	logic [PtrW-1:0]     ptr_mem [NumBlocks];
	nfa_pkg::page_word_t page_mem [NumPages];

	logic [PtrW-1:0]     ptr_rd_q;
	nfa_pkg::page_word_t page_rd_q;
	nfa_pkg::cmd_t       cmd_q;
	logic [BidxW-1:0]    bidx_q;
	logic [PidxW-1:0]    pidx_q;

	logic                out_valid_q;
	nfa_pkg::rsp_t       out_data_q;

	logic [BidxW-1:0]    head_bidx;
	logic [PidxW-1:0]    head_pidx;
	logic                fetch;
	logic                slot_free;
	logic                exec_fire;
	nfa_pkg::status_t    exec_status;
	logic                ptr_upd;
	logic [PtrW-1:0]     ptr_new;
	logic                page_wr;
	logic                rd_hit;
	logic                ptr_we;
	logic [BidxW-1:0]    ptr_waddr;
	logic [PtrW-1:0]     ptr_wdata;
	logic                page_we;
	nfa_pkg::page_word_t page_wword;
	nfa_pkg::rsp_t       rsp_d;

	// flat block and page index of the queue head
	assign head_bidx = BidxW'(32'(q_cmd.bank_addr) * 32'(MAX_BLOCKS) + 32'(q_cmd.block_addr));
	assign head_pidx = PidxW'(32'(head_bidx) * 32'(MAX_PAGES) + 32'(q_cmd.page_addr));

	assign fetch     = (state_q == S_FETCH) && !clr_q && q_valid;
	assign q_pop     = fetch;
	assign slot_free = !out_valid_q || rsp.ready;
	assign exec_fire = (state_q == S_EXEC) && slot_free;
	assign stat.clearing = clr_q;

	// decide status and side effects from the fetched pointer
	always_comb begin
		exec_status = nfa_pkg::ST_INVALID;
		ptr_upd     = 1'b0;
		ptr_new     = '0;
		page_wr     = 1'b0;
		rd_hit      = 1'b0;
		case (cmd_q.op)
			nfa_pkg::OP_PROGRAM: begin
				if (32'(cmd_q.page_addr) < 32'(ptr_rd_q)) begin
					exec_status = nfa_pkg::ST_OVERWRITE;
				end else if (32'(cmd_q.page_addr) > 32'(ptr_rd_q)) begin
					exec_status = nfa_pkg::ST_POSITION;
				end else begin
					exec_status = nfa_pkg::ST_OK;
					ptr_upd     = 1'b1;
					ptr_new     = ptr_rd_q + 1'b1;
					page_wr     = 1'b1;
				end
			end
			nfa_pkg::OP_READ: begin
				if (32'(cmd_q.page_addr) >= 32'(ptr_rd_q)) begin
					exec_status = nfa_pkg::ST_EMPTY;
				end else begin
					exec_status = nfa_pkg::ST_OK;
					rd_hit      = 1'b1;
				end
			end
			nfa_pkg::OP_ERASE: begin
				if (ptr_rd_q == '0) begin
					exec_status = nfa_pkg::ST_EMPTY;
				end else begin
					exec_status = nfa_pkg::ST_OK;
					ptr_upd     = 1'b1;
				end
			end
			default: exec_status = nfa_pkg::ST_INVALID;
		endcase
	end

	// pointer table write port: clearing sweep or command update
	assign ptr_we    = clr_q || (exec_fire && ptr_upd);
	assign ptr_waddr = clr_q ? clr_cnt_q : bidx_q;
	assign ptr_wdata = clr_q ? '0 : ptr_new;

	assign page_we          = exec_fire && page_wr;
	assign page_wword.spare = cmd_q.wspare;
	assign page_wword.d3    = cmd_q.wdata3;
	assign page_wword.d2    = cmd_q.wdata2;
	assign page_wword.d1    = cmd_q.wdata1;
	assign page_wword.d0    = cmd_q.wdata0;

	// build the response word; data is zero unless the read hit
	always_comb begin
		rsp_d.status = exec_status;
		rsp_d.rdata0 = rd_hit ? page_rd_q.d0 : '0;
		rsp_d.rdata1 = rd_hit ? page_rd_q.d1 : '0;
		rsp_d.rdata2 = rd_hit ? page_rd_q.d2 : '0;
		rsp_d.rdata3 = rd_hit ? page_rd_q.d3 : '0;
		rsp_d.rspare = rd_hit ? page_rd_q.spare : '0;
	end

	// pointer table
	always_ff @(posedge clk) begin
		if (ptr_we) ptr_mem[ptr_waddr] <= ptr_wdata;
		if (fetch && (q_cmd.op != nfa_pkg::OP_REJECT)) ptr_rd_q <= ptr_mem[head_bidx];
	end

	// page memory
	always_ff @(posedge clk) begin
		if (page_we) page_mem[pidx_q] <= page_wword;
		if (fetch && (q_cmd.op != nfa_pkg::OP_REJECT)) page_rd_q <= page_mem[head_pidx];
	end

	// capture the fetched command
	always_ff @(posedge clk) begin
		if (fetch) begin
			cmd_q  <= q_cmd;
			bidx_q <= head_bidx;
			pidx_q <= head_pidx;
		end
	end

	// sweep the pointer table after reset and after a register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clear_req) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			if (clr_cnt_q == BidxW'(NumBlocks - 1)) clr_q <= 1'b0;
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FETCH;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (rsp.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_FETCH: begin
					if (fetch) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (exec_fire) begin
						out_valid_q <= 1'b1;
						out_data_q  <= rsp_d;
						state_q     <= S_FETCH;
					end
				end
				default: state_q <= S_FETCH;
			endcase
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;

	// no command leaves the queue while the table is swept
	a_no_fetch_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !q_pop)
		else $error("command fetched during pointer sweep");

	// flag a command update that meets the sweep; the sweep has the pointer write port
	a_no_exec_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !(exec_fire && (ptr_upd || page_wr)))
		else $error("command update during pointer sweep");

	// a pointer never passes the page count
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_we |-> (32'(ptr_wdata) <= 32'(MAX_PAGES)))
		else $error("block pointer beyond page count");

	// a successful program moves the pointer just past the written page
	a_prog_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		page_we |-> (ptr_we && (32'(ptr_wdata) == 32'(cmd_q.page_addr) + 32'd1)))
		else $error("program without matching pointer advance");

	// an executed command shows a response word in the next cycle
	a_exec_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire |=> out_valid_q)
		else $error("executed command lost its response");

endmodule
